FILE: sv/sorted_table_binary_search_macros.svh
// Assertion macros used by the checker file of the sorted table search.
`ifndef SORTED_TABLE_BINARY_SEARCH_MACROS_SVH
`define SORTED_TABLE_BINARY_SEARCH_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define STBS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sorted table search: check failed");

// Next-cycle implication, disabled while reset is asserted.
`define STBS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sorted table search: check failed");

// Next-cycle implication that is also checked across reset.
`define STBS_ASSERT_NXT_ALWAYS(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("sorted table search: reset check failed");

`endif

FILE: sv/stbs_pkg.sv
// ----------------------------------------------------------------------------
// stbs_pkg
// Types and constants shared by the sorted table search controller and
// datapath.
// ----------------------------------------------------------------------------
package stbs_pkg;

    // Width of a table index as carried on the request channel.
    localparam int IDX_W = 8;
    // Working width of the search bounds: holds -1 up to one past the
    // largest index, and the sum of two bounds.
    localparam int POS_W = 10;

    typedef enum logic {
        OP_LOAD   = 1'b0,
        OP_SEARCH = 1'b1
    } t_opcode;

    typedef logic signed [POS_W-1:0] t_pos;

    typedef struct packed {
        logic load;         // write the request's entry into the table
        logic capture;      // latch key and range of a search request
        logic start;        // issue the first probe
        logic step;         // narrow the range and issue the next probe
        logic finish_hit;   // record a match at the current probe
        logic finish_miss;  // record an empty range
        logic out_load;     // move the recorded result to the output register
    } t_dp_cmd;

    typedef struct packed {
        logic empty;        // captured range holds no entry
        logic hit;          // probed entry equals the key
        logic next_empty;   // the narrowed range would hold no entry
    } t_dp_stat;

endpackage

FILE: sv/stbs_if.sv
// ----------------------------------------------------------------------------
// stbs_req_if / stbs_resp_if
// Valid/ready channels for table requests and search results.
// ----------------------------------------------------------------------------
interface stbs_req_if;
    logic               valid;
    logic               ready;
    logic               opcode;
    logic        [7:0]  entry_index;
    logic signed [31:0] entry_value;
    logic signed [31:0] search_key;
    logic        [7:0]  range_low;
    logic signed [8:0]  range_high;

    modport source (
        output valid, opcode, entry_index, entry_value, search_key, range_low,
               range_high,
        input  ready
    );
    modport sink (
        input  valid, opcode, entry_index, entry_value, search_key, range_low,
               range_high,
        output ready
    );
endinterface

interface stbs_resp_if;
    logic       valid;
    logic       ready;
    logic       found;
    logic [7:0] position;

    modport source (
        output valid, found, position,
        input  ready
    );
    modport sink (
        input  valid, found, position,
        output ready
    );
endinterface

FILE: sv/stbs_ram.sv
// ----------------------------------------------------------------------------
// stbs_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module stbs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: sv/stbs_dp.sv
// ----------------------------------------------------------------------------
// stbs_dp
// Search datapath: table memory, range bounds, probe compare and result
// registers.
// ----------------------------------------------------------------------------
module stbs_dp #(
    parameter int TABLE_DEPTH = 256,
    parameter int WORD_WIDTH  = 32
) (
    input  logic               i_clk,
    input  stbs_pkg::t_dp_cmd  i_cmd,
    output stbs_pkg::t_dp_stat o_stat,
    input  logic        [7:0]  i_entry_index,
    input  logic signed [31:0] i_entry_value,
    input  logic signed [31:0] i_search_key,
    input  logic        [7:0]  i_range_low,
    input  logic signed [8:0]  i_range_high,
    output logic               o_found,
    output logic        [7:0]  o_position
);
    import stbs_pkg::*;

    localparam int AW      = $clog2(TABLE_DEPTH);
    localparam int IW      = (AW > IDX_W) ? AW : IDX_W;
    localparam int LastIdx = TABLE_DEPTH - 1;

    logic [WORD_WIDTH-1:0] r_key;
    t_pos                  r_lo;
    t_pos                  r_hi;
    logic [IDX_W-1:0]      r_mid;
    logic                  r_found;
    logic [IDX_W-1:0]      r_pos;
    logic                  r_out_found;
    logic [IDX_W-1:0]      r_out_pos;

    t_pos                  lo_in;
    t_pos                  hi_in;
    t_pos                  sum_start;
    logic [IDX_W-1:0]      mid_start;
    logic [WORD_WIDTH-1:0] probe;
    logic                  key_below;
    t_pos                  mid_p1;
    t_pos                  mid_m1;
    t_pos                  nlo;
    t_pos                  nhi;
    t_pos                  sum_next;
    logic [IDX_W-1:0]      next_mid;
    logic [IDX_W-1:0]      rd_mid;
    logic [IW-1:0]         rd_ext;
    logic [IW-1:0]         wr_ext;
    logic                  we;

    // Range end beyond the table is clipped to the last entry.
    always_comb begin
        lo_in = t_pos'(i_range_low);
        hi_in = t_pos'(i_range_high);
        if (i_range_high > LastIdx) begin
            hi_in = t_pos'(LastIdx);
        end
    end

    assign sum_start = r_lo + r_hi;
    assign mid_start = sum_start[IDX_W:1];

    assign key_below = $signed(r_key) < $signed(probe);
    assign mid_p1    = t_pos'(r_mid) + t_pos'(1);
    assign mid_m1    = t_pos'(r_mid) - t_pos'(1);
    assign nlo       = key_below ? r_lo : mid_p1;
    assign nhi       = key_below ? mid_m1 : r_hi;
    assign sum_next  = nlo + nhi;
    assign next_mid  = sum_next[IDX_W:1];

    assign o_stat.empty      = r_lo > r_hi;
    assign o_stat.hit        = probe == r_key;
    assign o_stat.next_empty = nlo > nhi;

    // The next probe address is formed in the same cycle as the compare.
    assign rd_mid = i_cmd.step ? next_mid : mid_start;
    assign rd_ext = IW'(rd_mid);
    assign wr_ext = IW'(i_entry_index);
    assign we     = i_cmd.load && (int'(i_entry_index) < TABLE_DEPTH);

    stbs_ram #(
        .WIDTH(WORD_WIDTH),
        .DEPTH(TABLE_DEPTH)
    ) u_table (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(wr_ext[AW-1:0]),
        .i_wdata(WORD_WIDTH'($unsigned(i_entry_value))),
        .i_raddr(rd_ext[AW-1:0]),
        .o_rdata(probe)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_key <= WORD_WIDTH'($unsigned(i_search_key));
            r_lo  <= lo_in;
            r_hi  <= hi_in;
        end
        if (i_cmd.start) begin
            r_mid <= mid_start;
        end
        if (i_cmd.step) begin
            r_lo  <= nlo;
            r_hi  <= nhi;
            r_mid <= next_mid;
        end
        if (i_cmd.finish_hit) begin
            r_found <= 1'b1;
            r_pos   <= r_mid;
        end
        if (i_cmd.finish_miss) begin
            r_found <= 1'b0;
            r_pos   <= '0;
        end
        if (i_cmd.out_load) begin
            r_out_found <= r_found;
            r_out_pos   <= r_pos;
        end
    end

    assign o_found    = r_out_found;
    assign o_position = r_out_pos;

endmodule

FILE: sv/stbs_ctrl.sv
// ----------------------------------------------------------------------------
// stbs_ctrl
// Controller for the sorted table search: sequences loads, probes and the
// hand-off of each result to the output register.
// ----------------------------------------------------------------------------
module stbs_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_req_valid,
    input  logic               i_req_opcode,
    output logic               o_req_ready,
    output logic               o_resp_valid,
    input  logic               i_resp_ready,
    output stbs_pkg::t_dp_cmd  o_cmd,
    input  stbs_pkg::t_dp_stat i_stat
);
    import stbs_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_START,
        S_PROBE,
        S_RESULT
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   accept;
    logic   slot_free;

    assign accept    = i_req_valid && o_req_ready;
    assign slot_free = !r_out_valid || i_resp_ready;

    always_comb begin
        o_cmd       = '0;
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_resp_ready;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_req_opcode == OP_SEARCH) begin
                        o_cmd.capture = 1'b1;
                        n_state       = S_START;
                    end else begin
                        o_cmd.load = 1'b1;
                    end
                end
            end
            S_START: begin
                if (i_stat.empty) begin
                    o_cmd.finish_miss = 1'b1;
                    n_state           = S_RESULT;
                end else begin
                    o_cmd.start = 1'b1;
                    n_state     = S_PROBE;
                end
            end
            S_PROBE: begin
                priority if (i_stat.hit) begin
                    o_cmd.finish_hit = 1'b1;
                    n_state          = S_RESULT;
                end else if (i_stat.next_empty) begin
                    o_cmd.finish_miss = 1'b1;
                    n_state           = S_RESULT;
                end else begin
                    o_cmd.step = 1'b1;
                end
            end
            S_RESULT: begin
                // Wait here while the previous result is still unclaimed.
                if (slot_free) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_req_ready  = r_state == S_IDLE;
    assign o_resp_valid = r_out_valid;

endmodule

FILE: sv/sorted_table_binary_search.sv
// ----------------------------------------------------------------------------
// sorted_table_binary_search
// Binary search over a loadable table of signed words held sorted ascending.
// ----------------------------------------------------------------------------
// Requests arrive on i_req. A load request (opcode 0) writes entry_value at
// entry_index and gives no result; an index beyond the table
// is dropped. A search request (opcode 1) looks for search_key between
// range_low and range_high inclusive, with range_high clipped to the last
// entry, and gives one result on o_resp: found and the matching position,
// or found low with position 0.
// A search is set up first and then probes the table back to back, since each
// probe is one registered read of the table memory followed by a compare
// that already forms the next address. A search makes at most
// log2(TABLE_DEPTH)+1 probes; the result then waits in S_RESULT for a free
// output register, and the next request is taken as the result turns valid.
// Only one search is in flight at a time; loads are taken back to back.
// The output register holds a finished result while the receiver stalls;
// a following load is still taken, and a following search waits at its end
// until the earlier result has been taken.
// Reset clears the controller and the output valid; table contents are
// undefined until written, and only written entries may be probed.
// ----------------------------------------------------------------------------
module sorted_table_binary_search #(
    parameter int TABLE_DEPTH = 256,
    parameter int WORD_WIDTH  = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    stbs_req_if.sink    i_req,
    stbs_resp_if.source o_resp
);
    import stbs_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    stbs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .i_req_opcode(i_req.opcode),
        .o_req_ready (i_req.ready),
        .o_resp_valid(o_resp.valid),
        .i_resp_ready(o_resp.ready),
        .o_cmd       (cmd),
        .i_stat      (stat)
    );

    stbs_dp #(
        .TABLE_DEPTH(TABLE_DEPTH),
        .WORD_WIDTH (WORD_WIDTH)
    ) u_dp (
        .i_clk        (i_clk),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .i_entry_index(i_req.entry_index),
        .i_entry_value(i_req.entry_value),
        .i_search_key (i_req.search_key),
        .i_range_low  (i_req.range_low),
        .i_range_high (i_req.range_high),
        .o_found      (o_resp.found),
        .o_position   (o_resp.position)
    );

endmodule

FILE: sv/stbs_checker.sv
// ----------------------------------------------------------------------------
// stbs_checker
// Port-level checks of the sorted table search, attached by bind.
// ----------------------------------------------------------------------------
`include "sorted_table_binary_search_macros.svh"

module stbs_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_req_valid,
    input logic       i_req_ready,
    input logic       i_req_opcode,
    input logic       i_resp_valid,
    input logic       i_resp_ready,
    input logic       i_resp_found,
    input logic [7:0] i_resp_position
);
    import stbs_pkg::*;

    logic search_accept;
    logic resp_stall;

    assign search_accept = i_req_valid && i_req_ready && (i_req_opcode == OP_SEARCH);
    assign resp_stall    = i_resp_valid && !i_resp_ready;

    // A search is in flight after it is taken, so no request follows at once.
    `STBS_ASSERT_NXT(a_search_blocks, i_clk, i_rst_n, search_accept, !i_req_ready)

    // A miss always reports position zero.
    `STBS_ASSERT_IMP(a_miss_pos_zero, i_clk, i_rst_n, i_resp_valid && !i_resp_found, i_resp_position == 8'd0)

    `STBS_ASSERT_NXT(a_resp_hold, i_clk, i_rst_n, resp_stall, i_resp_valid)

    `STBS_ASSERT_NXT(a_resp_stable, i_clk, i_rst_n, resp_stall, $stable(i_resp_found) && $stable(i_resp_position))

    // Reset drops any pending result.
    `STBS_ASSERT_NXT_ALWAYS(a_reset_clears, i_clk, !i_rst_n, !i_resp_valid)

endmodule

bind sorted_table_binary_search stbs_checker u_stbs_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_req_valid    (i_req.valid),
    .i_req_ready    (i_req.ready),
    .i_req_opcode   (i_req.opcode),
    .i_resp_valid   (o_resp.valid),
    .i_resp_ready   (o_resp.ready),
    .i_resp_found   (o_resp.found),
    .i_resp_position(o_resp.position)
);
